// ----- hdl/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar helpers for the calendar date adder.
// ----------------------------------------------------------------------------
package cda_pkg;

  // Largest count that is honored; larger counts are clamped to it.
  localparam int COUNT_MAX = 1023;

  // Field widths of the request and result items.
  localparam int COUNT_W = 10;
  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  // Width of the step counter: enough for COUNT_MAX weeks in days.
  localparam int STEP_W = $clog2(COUNT_MAX * 7 + 1);

  // The year residue mod 25 is found four year bits per cycle.
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = YEAR_W / MOD_BITS;
  localparam int MODC_W    = $clog2(MOD_STEPS);

  localparam logic [YEAR_W-1:0] YEAR_MAX = '1;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_DAYS   = 2'd0,
    OP_WEEKS  = 2'd1,
    OP_MONTHS = 2'd2,
    OP_YEARS  = 2'd3
  } cda_op_t;

  localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mod_step;
    logic step;
    logic capture;
  } cda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } cda_sts_t;

  // Length of a month. The leap test uses the year's low four bits and the
  // year mod 25: a year is leap when it is a multiple of 4 and either not a
  // multiple of 25 or a multiple of 16 (that is, of 400).
  function automatic logic [DAY_W-1:0] days_in(input logic [3:0] y_lo,
                                                input logic [4:0] y25,
                                                input logic [MONTH_W-1:0] m);
    logic leap;
    logic [DAY_W-1:0] len;
    leap = (y_lo[1:0] == 2'd0) && ((y25 != 5'd0) || (y_lo == 4'd0));
    case (m)
      M_FEB:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/cda_if.sv -----
// ----------------------------------------------------------------------------
// cda_if
// Valid/ready channels for requests into and results out of the date adder.
// ----------------------------------------------------------------------------
interface cda_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [cda_pkg::COUNT_W-1:0]   count;
  logic [cda_pkg::YEAR_W-1:0]    start_year;
  logic [cda_pkg::MONTH_W-1:0]   start_month;
  logic [cda_pkg::DAY_W-1:0]     start_day;

  modport source (output valid, op, count, start_year, start_month, start_day,
                  input ready);
  modport sink   (input valid, op, count, start_year, start_month, start_day,
                  output ready);
endinterface

interface cda_out_if;
  logic                          valid;
  logic                          ready;
  logic [cda_pkg::YEAR_W-1:0]    end_year;
  logic [cda_pkg::MONTH_W-1:0]   end_month;
  logic [cda_pkg::DAY_W-1:0]     end_day;
  logic                          year_overflow;

  modport source (output valid, end_year, end_month, end_day, year_overflow,
                  input ready);
  modport sink   (input valid, end_year, end_month, end_day, year_overflow,
                  output ready);
endinterface

// ----- hdl/calendar_date_adder.sv -----
// Flow: an accepted request runs the year residue reduction, then the date
// walk of day or month steps, then the result capture; a count of N weeks
// takes 7*N day steps, a year add takes none. Requests are taken one at a
// time, a new one only once the last result is captured; the worst case is 1023 weeks, walked a day at a time.
// Reset: synchronous, active low; clears the controller and the result valid.
// ----------------------------------------------------------------------------
// calendar_date_adder
// Advances a Gregorian date by a count of days, weeks, months or years.
// ----------------------------------------------------------------------------
module calendar_date_adder (
  input  logic      clk,
  input  logic      rst_n,
  cda_in_if.sink    in_ch,
  cda_out_if.source out_ch
);
  import cda_pkg::*;

  cda_cmd_t cmd;
  cda_sts_t sts;

  // Sequencer for the request/result handshakes and the date walk.
  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Date registers, step counter and result register.
  cda_datapath u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_ch.op),
    .in_count          (in_ch.count),
    .in_start_year     (in_ch.start_year),
    .in_start_month    (in_ch.start_month),
    .in_start_day      (in_ch.start_day),
    .out_end_year      (out_ch.end_year),
    .out_end_month     (out_ch.end_month),
    .out_end_day       (out_ch.end_day),
    .out_year_overflow (out_ch.year_overflow)
  );

endmodule

// ----- hdl/cda_datapath.sv -----
// ----------------------------------------------------------------------------
// cda_datapath
// Date registers, step counter, year mod 25 unit and result register.
// ----------------------------------------------------------------------------
module cda_datapath (
  input  logic                          clk,
  input  cda_pkg::cda_cmd_t             cmd,
  output cda_pkg::cda_sts_t             sts,
  input  logic [1:0]                    in_op,
  input  logic [cda_pkg::COUNT_W-1:0]   in_count,
  input  logic [cda_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [cda_pkg::MONTH_W-1:0]   in_start_month,
  input  logic [cda_pkg::DAY_W-1:0]     in_start_day,
  output logic [cda_pkg::YEAR_W-1:0]    out_end_year,
  output logic [cda_pkg::MONTH_W-1:0]   out_end_month,
  output logic [cda_pkg::DAY_W-1:0]     out_end_day,
  output logic                          out_year_overflow
);
  import cda_pkg::*;

  logic [YEAR_W-1:0]  y_r, y_nxt;
  logic [MONTH_W-1:0] m_r, m_nxt;
  logic [DAY_W-1:0]   d_r, d_nxt;
  logic               ovf_r, ovf_nxt;
  logic               halt_r, halt_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [4:0]         y25_r, y25_nxt;
  logic [YEAR_W-1:0]  ysh_r, ysh_nxt;
  logic               months_r, months_nxt;

  logic [YEAR_W-1:0]  res_year_r;
  logic [MONTH_W-1:0] res_month_r;
  logic [DAY_W-1:0]   res_day_r;
  logic               res_ovf_r;

  // Clamped count and the number of single steps it asks for.
  logic [COUNT_W-1:0] cnt;
  logic [STEP_W-1:0]  cnt_ext;
  logic [STEP_W-1:0]  load_steps;
  logic [YEAR_W:0]    year_sum;
  logic [MONTH_W-1:0] m_fix;
  logic [DAY_W-1:0]   d_fix;

  always_comb begin
    cnt = (32'(in_count) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : in_count;
    cnt_ext = STEP_W'(cnt);
    case (in_op)
      OP_DAYS, OP_MONTHS: load_steps = cnt_ext;
      OP_WEEKS:           load_steps = (cnt_ext << 3) - cnt_ext;
      default:            load_steps = '0;
    endcase
    year_sum = {1'b0, in_start_year} + (YEAR_W + 1)'(cnt);
    if (in_start_month == 4'd0) begin
      m_fix = M_JAN;
    end else if (in_start_month > M_DEC) begin
      m_fix = M_DEC;
    end else begin
      m_fix = in_start_month;
    end
    d_fix = (in_start_day == '0) ? DAY_W'(1) : in_start_day;
  end

  // One digit of the year mod 25 reduction: four year bits per cycle.
  logic [4:0] mod_acc;
  logic [5:0] mod_t;

  always_comb begin
    mod_acc = y25_r;
    mod_t   = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      mod_t = {mod_acc, ysh_r[YEAR_W-1-i]};
      if (mod_t >= 6'd25) begin
        mod_t = mod_t - 6'd25;
      end
      mod_acc = mod_t[4:0];
    end
  end

  // Candidate next month and year, with the residue kept in step.
  logic               at_dec;
  logic               at_max;
  logic [YEAR_W-1:0]  y_inc;
  logic [4:0]         y25_inc;
  logic [MONTH_W-1:0] m_adv;
  logic [DAY_W-1:0]   len_cur;
  logic [DAY_W-1:0]   len_adv;

  always_comb begin
    at_dec  = (m_r == M_DEC);
    at_max  = (y_r == YEAR_MAX);
    y_inc   = at_dec ? y_r + YEAR_W'(1) : y_r;
    y25_inc = at_dec ? ((y25_r == 5'd24) ? 5'd0 : y25_r + 5'd1) : y25_r;
    m_adv   = at_dec ? M_JAN : m_r + MONTH_W'(1);
    len_cur = days_in(y_r[3:0], y25_r, m_r);
    len_adv = days_in(y_inc[3:0], y25_inc, m_adv);
  end

  // Next-state logic of the date registers.
  always_comb begin
    y_nxt      = y_r;
    m_nxt      = m_r;
    d_nxt      = d_r;
    ovf_nxt    = ovf_r;
    halt_nxt   = halt_r;
    steps_nxt  = steps_r;
    y25_nxt    = y25_r;
    ysh_nxt    = ysh_r;
    months_nxt = months_r;
    if (cmd.load) begin
      m_nxt      = m_fix;
      d_nxt      = d_fix;
      halt_nxt   = 1'b0;
      steps_nxt  = load_steps;
      y25_nxt    = '0;
      ysh_nxt    = in_start_year;
      months_nxt = (in_op == OP_MONTHS);
      if (in_op == OP_YEARS) begin
        y_nxt   = year_sum[YEAR_W] ? YEAR_MAX : year_sum[YEAR_W-1:0];
        ovf_nxt = year_sum[YEAR_W];
      end else begin
        y_nxt   = in_start_year;
        ovf_nxt = 1'b0;
      end
    end else if (cmd.mod_step) begin
      y25_nxt = mod_acc;
      ysh_nxt = ysh_r << MOD_BITS;
    end else if (cmd.step) begin
      steps_nxt = steps_r - STEP_W'(1);
      if (months_r) begin
        // Month step: advance the month and cap the day.
        if (at_dec && at_max) begin
          ovf_nxt  = 1'b1;
          halt_nxt = 1'b1;
        end else begin
          y_nxt   = y_inc;
          y25_nxt = y25_inc;
          m_nxt   = m_adv;
          d_nxt   = (d_r > len_adv) ? len_adv : d_r;
        end
      end else if (d_r >= len_cur) begin
        // Day step at the end of a month.
        if (at_dec && at_max) begin
          d_nxt    = 5'd31;
          ovf_nxt  = 1'b1;
          halt_nxt = 1'b1;
        end else begin
          y_nxt   = y_inc;
          y25_nxt = y25_inc;
          m_nxt   = m_adv;
          d_nxt   = DAY_W'(1);
        end
      end else begin
        d_nxt = d_r + DAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    y_r      <= y_nxt;
    m_r      <= m_nxt;
    d_r      <= d_nxt;
    ovf_r    <= ovf_nxt;
    halt_r   <= halt_nxt;
    steps_r  <= steps_nxt;
    y25_r    <= y25_nxt;
    ysh_r    <= ysh_nxt;
    months_r <= months_nxt;
  end

  // Result register, loaded once the walk has finished.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_year_r  <= y_r;
      res_month_r <= m_r;
      res_day_r   <= d_r;
      res_ovf_r   <= ovf_r;
    end
  end

  assign sts.done          = (steps_r == '0) || halt_r;
  assign out_end_year      = res_year_r;
  assign out_end_month     = res_month_r;
  assign out_end_day       = res_day_r;
  assign out_year_overflow = res_ovf_r;

endmodule

// ----- hdl/cda_ctrl.sv -----
// ----------------------------------------------------------------------------
// cda_ctrl
// Controller: accepts a request, sequences the datapath, hands off a result.
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cda_pkg::cda_cmd_t  cmd,
  input  cda_pkg::cda_sts_t  sts
);
  import cda_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_RUN,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [MODC_W-1:0] modc_r, modc_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Commands are decoded from the state, the handshakes and the done status.
  always_comb begin
    cmd.load     = in_valid && (state_r == S_IDLE);
    cmd.mod_step = (state_r == S_MOD);
    cmd.step     = (state_r == S_RUN) && !sts.done;
    cmd.capture  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  end

  // Next state, step counter for the residue unit, and result valid.
  always_comb begin
    state_nxt     = state_r;
    modc_nxt      = modc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MOD;
          modc_nxt  = '0;
        end
      end
      S_MOD: begin
        modc_nxt = modc_r + MODC_W'(1);
        if (modc_r == MODC_W'(MOD_STEPS - 1)) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (cmd.capture) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modc_r      <= modc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // An accepted request always starts the residue reduction.
  a_accept_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MOD))
    else $error("accepted request did not start the residue reduction");

  // No date step is issued once the walk is finished.
  a_no_step_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.done)
    else $error("date step issued after the walk finished");

  // A result is only captured when the output register is free.
  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid_r || out_ready))
    else $error("result captured over an untaken result");

  // The result valid only rises out of the finish state.
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result valid rose outside the finish state");
`endif

endmodule
